// ===== sv/ufrc_pkg.sv =====
// shared types and constants for the union-find unit
// no dependencies
package ufrc_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int TBL_DEPTH    = MAX_ELEMENTS + 1;
    localparam int IDX_W        = 11;
    localparam int ENT_W        = 12;
    localparam int RANK_LIMIT   = 2047;

    localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(1024);
    localparam logic [IDX_W-1:0] MAX_IDX     = IDX_W'(MAX_ELEMENTS);

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_CMP_RD,
        S_CMP_WR,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             bad;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] root;
        logic             joined;
        logic             bad;
    } t_res;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [ENT_W-1:0] wdata;
    } t_ram_req;

endpackage

// ===== sv/ufrc_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module ufrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ufrc_ctrl.sv =====
// sequencer for root walks, path compression, linking and table clearing
// depends on ufrc_pkg
module ufrc_ctrl import ufrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  t_req             i_req,
    output logic             o_idle,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_res_ack,
    output t_ram_req         o_ram,
    input  logic [ENT_W-1:0] i_ram_rdata
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_start, n_start;
    logic [IDX_W-1:0] r_root, n_root;
    logic [IDX_W-1:0] r_rank, n_rank;
    logic [IDX_W-1:0] r_root1, n_root1;
    logic [IDX_W-1:0] r_rank1, n_rank1;
    logic [IDX_W-1:0] r_b, n_b;
    logic             r_op, n_op;
    logic             r_pass, n_pass;
    t_res             r_res, n_res;

    logic             d_is_link;
    logic [ENT_W-1:0] d_neg;

    assign d_is_link = !i_ram_rdata[ENT_W-1] && (i_ram_rdata != '0);
    assign d_neg     = ENT_W'(0) - i_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_cur   <= n_cur;
        r_start <= n_start;
        r_root  <= n_root;
        r_rank  <= n_rank;
        r_root1 <= n_root1;
        r_rank1 <= n_rank1;
        r_b     <= n_b;
        r_op    <= n_op;
        r_pass  <= n_pass;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cur   = r_cur;
        n_start = r_start;
        n_root  = r_root;
        n_rank  = r_rank;
        n_root1 = r_root1;
        n_rank1 = r_rank1;
        n_b     = r_b;
        n_op    = r_op;
        n_pass  = r_pass;
        n_res   = r_res;
        o_ram   = '{we: 1'b0, addr: r_cur, wdata: '0};

        unique case (r_state)
            S_CLEAR: begin
                o_ram = '{we: 1'b1, addr: r_clr, wdata: '0};
                n_clr = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op   = i_req.op;
                    n_b    = i_req.b;
                    n_pass = 1'b0;
                    if (i_req.bad) begin
                        n_res   = '{root: '0, joined: 1'b0, bad: 1'b1};
                        n_state = S_DONE;
                    end else begin
                        o_ram.addr = i_req.a;
                        n_cur      = i_req.a;
                        n_start    = i_req.a;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (d_is_link) begin
                    o_ram.addr = i_ram_rdata[IDX_W-1:0];
                    n_cur      = i_ram_rdata[IDX_W-1:0];
                end else begin
                    n_root  = r_cur;
                    n_rank  = d_neg[IDX_W-1:0];
                    n_cur   = r_start;
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                if (r_cur != r_root) begin
                    o_ram.addr = r_cur;
                    n_state    = S_CMP_WR;
                end else if (r_op == OP_FIND) begin
                    n_res   = '{root: r_root, joined: 1'b0, bad: 1'b0};
                    n_state = S_DONE;
                end else if (!r_pass) begin
                    n_root1    = r_root;
                    n_rank1    = r_rank;
                    n_pass     = 1'b1;
                    o_ram.addr = r_b;
                    n_cur      = r_b;
                    n_start    = r_b;
                    n_state    = S_WALK;
                end else if (r_root == r_root1) begin
                    n_res   = '{root: r_root1, joined: 1'b0, bad: 1'b0};
                    n_state = S_DONE;
                end else if (r_rank > r_rank1) begin
                    o_ram   = '{we: 1'b1, addr: r_root1, wdata: {1'b0, r_root}};
                    n_res   = '{root: r_root, joined: 1'b1, bad: 1'b0};
                    n_state = S_DONE;
                end else if (r_rank == r_rank1 && r_rank1 < IDX_W'(RANK_LIMIT)) begin
                    o_ram   = '{we: 1'b1, addr: r_root1,
                                wdata: ENT_W'(0) - ({1'b0, r_rank1} + ENT_W'(1))};
                    n_state = S_LINK;
                end else begin
                    o_ram   = '{we: 1'b1, addr: r_root, wdata: {1'b0, r_root1}};
                    n_res   = '{root: r_root1, joined: 1'b1, bad: 1'b0};
                    n_state = S_DONE;
                end
            end
            S_CMP_WR: begin
                o_ram   = '{we: 1'b1, addr: r_cur, wdata: {1'b0, r_root}};
                n_cur   = i_ram_rdata[IDX_W-1:0];
                n_state = S_CMP_RD;
            end
            S_LINK: begin
                o_ram   = '{we: 1'b1, addr: r_root, wdata: {1'b0, r_root1}};
                n_res   = '{root: r_root1, joined: 1'b1, bad: 1'b0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== sv/union_find_rank_compress_unit.sv =====
// a bad index goes straight to the result; a find walks to the root, then compresses the path
// a union does this for both elements, then links the roots if they differ; a rank tie adds a write
// one word at a time: the next is taken only once the result of the last is registered
// reset: synchronous active low; afterwards the table is cleared before input is taken
// depends on ufrc_pkg, ufrc_ctrl, ufrc_ram
module union_find_rank_compress_unit import ufrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [IDX_W-1:0] i_elem_a,
    input  logic [IDX_W-1:0] i_elem_b,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_root,
    output logic             o_joined,
    output logic             o_bad_index,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_data
);

    logic [IDX_W-1:0] r_count;
    logic             r_out_valid;
    t_res             r_out;

    logic             idle;
    logic             res_valid;
    logic             res_ack;
    t_res             res;
    t_req             req;
    t_ram_req         ram_req;
    logic [ENT_W-1:0] ram_rdata;
    logic [IDX_W-1:0] eff_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    assign eff_count = (r_count > MAX_IDX) ? MAX_IDX : r_count;

    always_comb begin
        req.op  = i_op;
        req.a   = i_elem_a;
        req.b   = i_elem_b;
        req.bad = (i_elem_a == '0) || (i_elem_a > eff_count)
               || ((i_op == OP_UNION) && ((i_elem_b == '0) || (i_elem_b > eff_count)));
    end

    ufrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (req),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ack   (res_ack),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    ufrc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    assign res_ack = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_root      = r_out.root;
    assign o_joined    = r_out.joined;
    assign o_bad_index = r_out.bad;

endmodule

// ===== tb/tb_union_find_rank_compress_unit.sv =====
// self-checking testbench for union_find_rank_compress_unit: finds and unions against a
// behavioral disjoint-set forest, with random stalls on both channels
// depends on ufrc_pkg and the union_find_rank_compress_unit rtl
`timescale 1ns / 1ps

module tb_union_find_rank_compress_unit import ufrc_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_WORDS    = 190;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             i_op        = OP_FIND;
    logic [IDX_W-1:0] i_elem_a    = '0;
    logic [IDX_W-1:0] i_elem_b    = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [IDX_W-1:0] i_cfg_data  = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [IDX_W-1:0] o_root;
    logic             o_joined;
    logic             o_bad_index;
    logic             o_cfg_ready;

    always #5 i_clk = ~i_clk;

    union_find_rank_compress_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_root      (o_root),
        .o_joined    (o_joined),
        .o_bad_index (o_bad_index),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    int               forest [0:MAX_ELEMENTS];
    logic [IDX_W-1:0] elem_count = COUNT_RESET;
    t_res             pending_roots [$];
    int               mismatches  = 0;
    int               idle_cycles = 0;
    int               out_stall   = 0;
    bit               in_tight    = 1'b0;
    bit               out_tight   = 1'b0;

    // walk to the root, then point the whole path at it
    function automatic int seek_root(int x);
        int r;
        int steps;
        int nxt;
        r = x;
        steps = 0;
        while (forest[r] > 0 && steps < MAX_ELEMENTS) begin
            r = forest[r];
            steps++;
        end
        steps = 0;
        while (x != r && forest[x] > 0 && steps < MAX_ELEMENTS) begin
            nxt = forest[x];
            forest[x] = r;
            x = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic t_res predict_union_find(logic op, logic [IDX_W-1:0] a,
                                                logic [IDX_W-1:0] b);
        t_res res;
        int   n;
        int   r1;
        int   r2;
        int   rank1;
        int   rank2;
        res = '0;
        n = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
        res.bad = (a == 0 || a > n);
        if (op == OP_UNION && (b == 0 || b > n))
            res.bad = 1'b1;
        if (!res.bad) begin
            if (op == OP_FIND) begin
                res.root = IDX_W'(seek_root(a));
            end else begin
                r1 = seek_root(a);
                r2 = seek_root(b);
                if (r1 == r2) begin
                    res.root = IDX_W'(r1);
                end else begin
                    rank1 = -forest[r1];
                    rank2 = -forest[r2];
                    if (rank2 > rank1) begin
                        forest[r1] = r2;
                        res.root = IDX_W'(r2);
                    end else begin
                        if (rank1 == rank2 && rank1 < RANK_LIMIT)
                            forest[r1] = -(rank1 + 1);
                        forest[r2] = r1;
                        res.root = IDX_W'(r1);
                    end
                    res.joined = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        if (in_tight)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(logic op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_elem_a   <= a;
        i_elem_b   <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pending_roots.push_back(predict_union_find(op, a, b));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [IDX_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        elem_count = value;
    endtask

    // receiver side: random stalls, mostly short
    always @(posedge i_clk) begin
        if (out_stall > 0)
            out_stall--;
        else if (!out_tight && $urandom_range(0, 99) < 25)
            out_stall = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
        i_out_ready <= (out_stall == 0);
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected word root %0d joined %0b bad %0b",
                                          o_root, o_joined, o_bad_index));
            end else begin
                want = pending_roots.pop_front();
                if (o_root !== want.root)
                    report_mismatch($sformatf("root %0d, want %0d", o_root, want.root));
                if (o_joined !== want.joined)
                    report_mismatch($sformatf("joined %0b, want %0b", o_joined, want.joined));
                if (o_bad_index !== want.bad)
                    report_mismatch($sformatf("bad_index %0b, want %0b",
                                              o_bad_index, want.bad));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_word(OP_FIND, 11'd1, 11'd0);
        send_word(OP_FIND, MAX_IDX, 11'd2047);
        send_word(OP_FIND, 11'd0, 11'd5);
        send_word(OP_FIND, 11'd1025, 11'd1);
        send_word(OP_FIND, 11'd2047, 11'd2047);
        send_word(OP_UNION, 11'd1, 11'd0);
        send_word(OP_UNION, 11'd0, 11'd5);
        send_word(OP_UNION, 11'd5, 11'd2047);
    endtask

    task automatic test_link_rules();
        send_word(OP_UNION, 11'd1, 11'd2);
        send_word(OP_UNION, 11'd3, 11'd4);
        send_word(OP_UNION, 11'd1, 11'd3);
        send_word(OP_UNION, 11'd5, 11'd1);
        send_word(OP_FIND, 11'd4, 11'd0);
        send_word(OP_UNION, 11'd2, 11'd4);
        send_word(OP_UNION, 11'd7, 11'd7);
        send_word(OP_UNION, MAX_IDX, 11'd1);
        send_word(OP_UNION, 11'd600, 11'd601);
        send_word(OP_UNION, 11'd600, 11'd30);
        settle();
    endtask

    task automatic test_count_limits();
        write_count(11'd1);
        send_word(OP_FIND, 11'd1, 11'd0);
        send_word(OP_FIND, 11'd2, 11'd0);
        settle();
        write_count(11'd0);
        send_word(OP_FIND, 11'd1, 11'd1);
        settle();
        write_count(11'd2047);
        send_word(OP_FIND, MAX_IDX, 11'd0);
        send_word(OP_UNION, 11'd1025, 11'd3);
        settle();
        // lowered count still follows links that point above it
        write_count(11'd100);
        send_word(OP_FIND, 11'd30, 11'd0);
        send_word(OP_UNION, 11'd30, 11'd31);
        send_word(OP_FIND, 11'd600, 11'd0);
        settle();
    endtask

    function automatic logic [IDX_W-1:0] out_of_range(int neff);
        if ($urandom_range(0, 3) == 0)
            return '0;
        return IDX_W'($urandom_range(neff + 1, 2047));
    endfunction

    task automatic random_word(int neff);
        logic             op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        int               r;
        r  = $urandom_range(0, 99);
        op = ($urandom_range(0, 99) < 55) ? OP_UNION : OP_FIND;
        if (neff == 0) begin
            a = IDX_W'($urandom_range(0, 2047));
            b = IDX_W'($urandom_range(0, 2047));
        end else begin
            a = IDX_W'($urandom_range(1, neff));
            b = (r < 4) ? a : IDX_W'($urandom_range(1, neff));
        end
        if (op == OP_FIND && $urandom_range(0, 3) == 0)
            b = IDX_W'($urandom_range(0, 2047));
        if (r >= 90) begin
            case (r % 3)
                0: a = out_of_range(neff);
                1: b = out_of_range(neff);
                default: begin
                    a = out_of_range(neff);
                    b = out_of_range(neff);
                end
            endcase
        end
        send_word(op, a, b);
    endtask

    task automatic test_random_phases();
        logic [IDX_W-1:0] counts [9];
        int               neff;
        counts = '{11'd16, 11'd1024, 11'd5, 11'd300, 11'd1024, 11'd2, 11'd2047, 11'd64,
                   11'd1024};
        foreach (counts[p]) begin
            write_count(counts[p]);
            neff = (counts[p] > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(counts[p]);
            in_tight  = (p % 3 == 1);
            out_tight = (p % 4 == 2);
            repeat (PHASE_WORDS) random_word(neff);
            settle();
        end
        in_tight  = 1'b0;
        out_tight = 1'b0;
    endtask

    initial begin
        foreach (forest[i])
            forest[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_link_rules();
        test_count_limits();
        test_random_phases();
        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ufrc_pkg.sv
sv/ufrc_ram.sv
sv/ufrc_ctrl.sv
sv/union_find_rank_compress_unit.sv
tb/tb_union_find_rank_compress_unit.sv
